// ----- src/rgb_brightness_contrast_adjust_assert.svh -----
// Assertion macros for the brightness and contrast block.
// Each macro checks a property on the rising edge of clk_i, with checking
// held off while rst_ni is low.
`ifndef RGB_BRIGHTNESS_CONTRAST_ADJUST_ASSERT_SVH
`define RGB_BRIGHTNESS_CONTRAST_ADJUST_ASSERT_SVH

`ifndef SYNTH
`define RBCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RBCA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RBCA_ASSERT(lbl, prop, msg)
`define RBCA_NEVER(lbl, cond, msg)
`endif

`endif

// ----- src/rbca_pkg.sv -----
`timescale 1ns / 1ps

package rbca_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned LutAddrW = 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned ChanLimit  = 250;
  localparam int unsigned ChanMax    = 255;
  localparam int unsigned MidLevel   = 128;
  localparam int unsigned PctFull    = 100;
  localparam int unsigned PctQuarter = 25;

  // Reciprocal of 100 is Recip / 2**ShiftHundred, of 25 is Recip / 2**ShiftQuarter.
  localparam int unsigned Recip        = 5243;
  localparam int unsigned RecipW       = 13;
  localparam int unsigned ShiftHundred = 19;
  localparam int unsigned ShiftQuarter = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBrightness = 2'd0,
    CfgContrast   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [ChanW-1:0] brightness;
    logic signed [ChanW-1:0] contrast;
  } settings_t;

  typedef struct packed {
    logic                we;
    logic [LutAddrW-1:0] addr;
    logic [ChanW-1:0]    data;
  } lut_wr_t;

  // Written settings saturate to the range -100..+100.
  function automatic logic signed [ChanW-1:0] sat_setting(input logic [ChanW-1:0] v);
    logic signed [ChanW-1:0] s;
    s = $signed(v);
    if (s > 8'sd100) begin
      return 8'sd100;
    end else if (s < -8'sd100) begin
      return -8'sd100;
    end
    return s;
  endfunction

endpackage

// ----- src/rbca_lut_calc.sv -----
`timescale 1ns / 1ps

// Sweeps all 256 channel codes through a pipelined evaluation of the
// brightness and contrast curve and writes each result into the tables.
module rbca_lut_calc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rbca_pkg::settings_t settings_i,
  output logic                busy_o,
  output rbca_pkg::lut_wr_t   lut_wr_o
);
  import rbca_pkg::*;

  logic                sweep_q, sweep_d;
  logic [LutAddrW-1:0] cnt_q, cnt_d;

  logic [5:0] v_q, v_d;

  logic [ChanW-1:0] x1_q, x2_q, x3_q, x4_q, x5_q, x6_q;
  logic [ChanW-1:0] i1_q, i2_q;
  logic [ChanW-1:0] t3_q, t4_q, t5_q, t6_q;
  logic [14:0]      p1_q;
  logic [27:0]      q2_q;
  logic signed [16:0] prod4_q;
  logic signed [17:0] num5_q;
  logic [27:0]      mr6_q;
  logic             neg6_q;

  logic             b_neg, c_pos, c_zero, bypass;
  logic [ChanW-1:0] b_u, c_u;
  logic [ChanW-1:0] i_lim, mul_a, bsum;
  logic [6:0]       mul_b;
  logic [8:0]       qd, t_sum;
  logic [ChanW-1:0] ksum;
  logic signed [8:0]  diff;
  logic signed [16:0] prod;
  logic signed [17:0] num;
  logic [10:0]      r_full;
  logic [ChanW-1:0] r_out;

  assign b_u    = settings_i.brightness;
  assign c_u    = settings_i.contrast;
  assign b_neg  = settings_i.brightness[ChanW-1];
  assign c_pos  = !settings_i.contrast[ChanW-1] && (settings_i.contrast != '0);
  assign c_zero = (settings_i.contrast == '0);
  assign bypass = (settings_i.brightness == '0) && c_zero;

  always_comb begin
    sweep_d = sweep_q;
    cnt_d   = cnt_q;
    if (start_i) begin
      sweep_d = 1'b1;
      cnt_d   = '0;
    end else if (sweep_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LutAddrW'(ChanMax)) begin
        sweep_d = 1'b0;
      end
    end
  end

  assign v_d = {v_q[4:0], sweep_q && !start_i};

  // Brightness product.
  always_comb begin
    i_lim = (cnt_q > ChanW'(ChanLimit)) ? ChanW'(ChanLimit) : cnt_q;
    bsum  = ChanW'(PctFull) + b_u;
    if (b_neg) begin
      mul_a = i_lim;
      mul_b = bsum[6:0];
    end else begin
      mul_a = ChanW'(ChanMax) - i_lim;
      mul_b = b_u[6:0];
    end
  end

  // Brightness quotient and contrast product.
  always_comb begin
    qd    = q2_q[27:ShiftHundred];
    t_sum = b_neg ? qd : ({1'b0, i2_q} + qd);
    diff  = $signed({1'b0, t3_q}) - 9'sd128;
    ksum  = (c_pos ? ChanW'(PctQuarter) : ChanW'(PctFull)) + c_u;
    prod  = diff * $signed({1'b0, ksum[6:0]});
    num   = {prod4_q[16], prod4_q} + (c_pos ? 18'sd3200 : 18'sd12800);
  end

  // Final quotient, clamp and the special cases.
  always_comb begin
    r_full = c_pos ? mr6_q[27:ShiftQuarter] : {2'b00, mr6_q[27:ShiftHundred]};
    if (neg6_q) begin
      r_out = '0;
    end else if (r_full > 11'(ChanMax)) begin
      r_out = ChanW'(ChanMax);
    end else begin
      r_out = r_full[ChanW-1:0];
    end
    if (c_zero) begin
      r_out = t6_q;
    end
    if (bypass) begin
      r_out = x6_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= 1'b0;
      cnt_q   <= '0;
      v_q     <= '0;
    end else begin
      sweep_q <= sweep_d;
      cnt_q   <= cnt_d;
      v_q     <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= cnt_q;
    i1_q    <= i_lim;
    p1_q    <= mul_a * mul_b;
    x2_q    <= x1_q;
    i2_q    <= i1_q;
    q2_q    <= p1_q * RecipW'(Recip);
    x3_q    <= x2_q;
    t3_q    <= t_sum[ChanW-1:0];
    x4_q    <= x3_q;
    t4_q    <= t3_q;
    prod4_q <= prod;
    x5_q    <= x4_q;
    t5_q    <= t4_q;
    num5_q  <= num;
    x6_q    <= x5_q;
    t6_q    <= t5_q;
    neg6_q  <= num5_q[17];
    mr6_q   <= num5_q[14:0] * RecipW'(Recip);
  end

  assign lut_wr_o.we   = v_q[5];
  assign lut_wr_o.addr = x6_q;
  assign lut_wr_o.data = r_out;
  assign busy_o        = sweep_q || (v_q != '0);

endmodule

// ----- src/rbca_lut_mem.sv -----
`timescale 1ns / 1ps

// One 256-entry table with a write port and a registered read port.
module rbca_lut_mem (
  input  logic                          clk_i,
  input  rbca_pkg::lut_wr_t             wr_i,
  input  logic                          rd_en_i,
  input  logic [rbca_pkg::LutAddrW-1:0] rd_addr_i,
  output logic [rbca_pkg::ChanW-1:0]    rd_data_o
);
  import rbca_pkg::*;

  logic [ChanW-1:0] mem [2**LutAddrW];
  logic [ChanW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/rgb_brightness_contrast_adjust.sv -----
`timescale 1ns / 1ps

// RGB brightness and contrast adjustment. Each pixel is mapped channel by
// channel through a 256-entry curve held in three identical synchronous
// tables, one per channel, so a pixel can be accepted on every clock cycle
// when no rebuild runs and the output is not stalled; its result passes
// the table read register, then the output register. The curve is rebuilt
// from the brightness and contrast settings by a pipelined calculator that
// writes one entry per cycle; s_axis_tready stays low while the tables are
// refilled (256 entries through the six-stage calculation pipeline) after
// every configuration write, and after reset also while the first rebuild
// is started. Configuration writes are always taken; they saturate
// to -100..+100 and should only be issued while no pixel is in flight.
module rgb_brightness_contrast_adjust (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Pixel input.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [3*rbca_pkg::ChanW-1:0] s_axis_tdata,  // red_in, green_in, blue_in
  // Pixel output.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [3*rbca_pkg::ChanW-1:0] m_axis_tdata,  // red_out, green_out, blue_out
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rbca_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rbca_pkg::ChanW-1:0]   cfg_data_i
);
  import rbca_pkg::*;

  `include "rgb_brightness_contrast_adjust_assert.svh"

  settings_t settings_q, settings_d;
  logic      init_q;
  logic      cfg_wr, start;
  logic      busy;
  lut_wr_t   lut_wr;

  logic      accept, adv1;
  logic      v1_q, v1_d, v2_q, v2_d;
  logic [3*ChanW-1:0] rd_data;
  logic [3*ChanW-1:0] out_q;

  // Configuration registers. A write to an index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    settings_d = settings_q;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        CfgBrightness: settings_d.brightness = sat_setting(cfg_data_i);
        CfgContrast:   settings_d.contrast   = sat_setting(cfg_data_i);
        default:       settings_d            = settings_q;
      endcase
    end
  end

  // The tables are rebuilt once after reset and after every write.
  assign start = init_q || cfg_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings_q <= '0;
      init_q     <= 1'b1;
    end else begin
      settings_q <= settings_d;
      init_q     <= 1'b0;
    end
  end

  rbca_lut_calc u_calc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .settings_i (settings_q),
    .busy_o     (busy),
    .lut_wr_o   (lut_wr)
  );

  // Stage one is the registered table read; stage two is the output
  // register. The table read data holds while stage one stalls, so a new
  // transaction is only taken when stage one is empty or moving on.
  assign adv1          = !v2_q || m_axis_tready;
  assign s_axis_tready = !busy && !init_q && (!v1_q || adv1);
  assign accept        = s_axis_tvalid && s_axis_tready;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    rbca_lut_mem u_mem (
      .clk_i     (clk_i),
      .wr_i      (lut_wr),
      .rd_en_i   (accept),
      .rd_addr_i (s_axis_tdata[ch*ChanW +: ChanW]),
      .rd_data_o (rd_data[ch*ChanW +: ChanW])
    );
  end

  always_comb begin
    v1_d = v1_q;
    v2_d = v2_q;
    if (adv1) begin
      v2_d = v1_q;
      v1_d = 1'b0;
    end
    if (accept) begin
      v1_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && v1_q) begin
      out_q <= rd_data;
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = out_q;

  // A configuration write must close the input until the tables are rebuilt.
  `RBCA_ASSERT(a_cfg_blocks_input, cfg_wr |=> !s_axis_tready, "input open after cfg write")
  // A table read never coincides with a table write.
  `RBCA_NEVER(a_no_rd_during_wr, accept && lut_wr.we, "table read during rebuild")
  // Stage one only fills from an input transaction.
  `RBCA_ASSERT(a_v1_from_accept, $rose(v1_q) |-> $past(accept), "stage one filled without input")

endmodule
